// ===== design/operand_list_reducer_assert.svh =====
`ifndef OPERAND_LIST_REDUCER_ASSERT_SVH
`define OPERAND_LIST_REDUCER_ASSERT_SVH

// Same-cycle check: whenever ante holds, cons must hold too.
`define OLR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check: whenever ante holds, cons must hold in the cycle after.
`define OLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/olr_pkg.sv =====
package olr_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DATA_W);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } olr_unit_ctl_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } olr_unit_sts_t;

endpackage

// ===== design/operand_list_reducer.sv =====
// Accumulator ALU that reduces a run of signed 32-bit operands. A transfer with
// in_is_first loads the accumulator with in_operand and clears the division
// error; each later transfer adds, subtracts, multiplies or divides (in_req_type
// 0..3) its operand into the accumulator, wrapping to 32 bits, with division
// truncating toward zero. Division by zero leaves the accumulator unchanged and
// sets the sticky div_error flag. A transfer with in_is_last produces one result
// transfer carrying the accumulator and the flag. Items are taken one at a time:
// in_stall stays high while an item is worked on. A first operand and a
// division by zero are settled in the execute state, an add or subtract in
// the iterative unit's idle state; multiply and divide run 32 iterations of
// the shared shift-and-add / restoring-divide unit plus setup and, for divide,
// sign correction. A finished result sits in the output register, so the next
// item can be accepted while the previous result still waits; the block only
// holds back when a new result is ready before the old one has been taken.
module operand_list_reducer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [olr_pkg::DATA_W-1:0]  in_operand,
  input  logic [1:0]                         in_req_type,
  input  logic                               in_is_first,
  input  logic                               in_is_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [olr_pkg::DATA_W-1:0]  out_result,
  output logic                               out_div_error
);
  import olr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [DATA_W-1:0] opnd_r, opnd_nxt;
  logic [1:0]        op_r, op_nxt;
  logic              first_r, first_nxt;
  logic              last_r, last_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic              err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_result_r, out_result_nxt;
  logic              out_err_r, out_err_nxt;

  olr_unit_ctl_t     u_ctl;
  olr_unit_sts_t     u_sts;
  logic              in_xfer;
  logic              out_free;
  logic              div_zero;
  logic              exec_first;
  logic              exec_div_zero;

  assign in_xfer  = in_valid && (state_r == S_IDLE);
  // The output register can take a new result when it is empty or being read.
  assign out_free = !out_valid_r || !out_stall;

  assign div_zero      = (op_r == OP_DIV) && (opnd_r == '0);
  assign exec_first    = (state_r == S_EXEC) && first_r;
  assign exec_div_zero = (state_r == S_EXEC) && !first_r && div_zero;

  assign u_ctl.start = (state_r == S_EXEC) && !first_r && !div_zero;
  assign u_ctl.op    = op_r;

  olr_iter_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (u_ctl),
    .a_i   (acc_r),
    .b_i   (opnd_r),
    .sts_o (u_sts)
  );

  always_comb begin
    state_nxt      = state_r;
    opnd_nxt       = opnd_r;
    op_nxt         = op_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    acc_nxt        = acc_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_result_nxt = out_result_r;
    out_err_nxt    = out_err_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          opnd_nxt  = $unsigned(in_operand);
          op_nxt    = in_req_type;
          first_nxt = in_is_first;
          last_nxt  = in_is_last;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (first_r) begin
          acc_nxt   = opnd_r;
          err_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (div_zero) begin
          // Division by zero: flag it and keep the accumulator as it is.
          err_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (u_sts.done) begin
          acc_nxt   = u_sts.result;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = acc_r;
          out_err_nxt    = err_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    opnd_r       <= opnd_nxt;
    op_r         <= op_nxt;
    first_r      <= first_nxt;
    last_r       <= last_nxt;
    out_result_r <= out_result_nxt;
    out_err_r    <= out_err_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_result    = $signed(out_result_r);
  assign out_div_error = out_err_r;

`include "operand_list_reducer_assert.svh"

  `OLR_ASSERT_NEXT(a_first_loads, exec_first, (acc_r == $past(opnd_r)) && !err_r, "bad run start")
  `OLR_ASSERT_NEXT(a_div_zero_flags, exec_div_zero, err_r && $stable(acc_r), "zero divide mishandled")
  `OLR_ASSERT_NOW(a_done_in_wait, u_sts.done, state_r == S_WAIT, "unit finished outside the wait state")

endmodule

// ===== design/olr_iter_unit.sv =====
module olr_iter_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  olr_pkg::olr_unit_ctl_t      ctl_i,
  input  logic [olr_pkg::DATA_W-1:0]  a_i,
  input  logic [olr_pkg::DATA_W-1:0]  b_i,
  output olr_pkg::olr_unit_sts_t      sts_o
);
  import olr_pkg::*;

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_RUN  = 2'd1;
  localparam logic [1:0] U_FIX  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] p_r, p_nxt;
  logic [DATA_W-1:0] m_r, m_nxt;
  logic [DATA_W-1:0] b_r, b_nxt;
  logic              neg_r, neg_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;

  logic [DATA_W:0]   add_x;
  logic [DATA_W-1:0] add_y;
  logic              add_sub;
  logic [DATA_W:0]   add_sum;
  logic [DATA_W-1:0] mag_a, mag_b;
  logic              run_last;

  // The shared adder/subtractor; its operands depend on the phase.
  always_comb begin
    add_x   = {1'b0, p_r};
    add_y   = m_r;
    add_sub = 1'b0;
    unique case (state_r)
      U_IDLE: begin
        add_x   = {1'b0, a_i};
        add_y   = b_i;
        add_sub = (ctl_i.op == OP_SUB);
      end
      U_RUN: begin
        if (op_r == OP_DIV) begin
          add_x   = {p_r, b_r[DATA_W-1]};
          add_y   = m_r;
          add_sub = 1'b1;
        end
      end
      U_FIX: begin
        add_x   = '0;
        add_y   = b_r;
        add_sub = neg_r;
      end
      default: begin
        add_x = {1'b0, p_r};
      end
    endcase
  end

  assign add_sum = add_x + ({1'b0, add_y} ^ {(DATA_W+1){add_sub}})
                 + {{DATA_W{1'b0}}, add_sub};

  assign mag_a = a_i[DATA_W-1] ? (DATA_W'(0) - a_i) : a_i;
  assign mag_b = b_i[DATA_W-1] ? (DATA_W'(0) - b_i) : b_i;

  assign run_last = (state_r == U_RUN) && (cnt_r == CNT_W'(DATA_W - 1));

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    p_nxt     = p_r;
    m_nxt     = m_r;
    b_nxt     = b_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    unique case (state_r)
      U_IDLE: begin
        if (ctl_i.start) begin
          op_nxt  = ctl_i.op;
          cnt_nxt = '0;
          p_nxt   = '0;
          unique case (ctl_i.op) inside
            OP_ADD, OP_SUB: begin
              res_nxt  = add_sum[DATA_W-1:0];
              done_nxt = 1'b1;
            end
            OP_MUL: begin
              m_nxt     = a_i;
              b_nxt     = b_i;
              state_nxt = U_RUN;
            end
            default: begin
              m_nxt     = mag_b;
              b_nxt     = mag_a;
              neg_nxt   = a_i[DATA_W-1] ^ b_i[DATA_W-1];
              state_nxt = U_RUN;
            end
          endcase
        end
      end
      U_RUN: begin
        if (op_r == OP_DIV) begin
          // Restoring step: keep the difference when it did not go negative.
          if (!add_sum[DATA_W]) begin
            p_nxt = add_sum[DATA_W-1:0];
          end else begin
            p_nxt = {p_r[DATA_W-2:0], b_r[DATA_W-1]};
          end
          b_nxt = {b_r[DATA_W-2:0], !add_sum[DATA_W]};
        end else begin
          if (b_r[0]) begin
            p_nxt = add_sum[DATA_W-1:0];
          end
          m_nxt = {m_r[DATA_W-2:0], 1'b0};
          b_nxt = {1'b0, b_r[DATA_W-1:1]};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DATA_W - 1)) begin
          state_nxt = U_FIX;
        end
      end
      U_FIX: begin
        res_nxt   = (op_r == OP_DIV) ? add_sum[DATA_W-1:0] : p_r;
        done_nxt  = 1'b1;
        state_nxt = U_IDLE;
      end
      default: begin
        state_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    p_r   <= p_nxt;
    m_r   <= m_nxt;
    b_r   <= b_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign sts_o.done   = done_r;
  assign sts_o.result = res_r;

`include "operand_list_reducer_assert.svh"

  `OLR_ASSERT_NOW(a_start_when_idle, ctl_i.start, state_r == U_IDLE, "unit started while busy")
  `OLR_ASSERT_NEXT(a_run_ends, run_last, state_r == U_FIX, "iteration count overran")
  `OLR_ASSERT_NEXT(a_fix_done, state_r == U_FIX, done_r && (state_r == U_IDLE), "no completion")

endmodule

// ===== tb/operand_list_reducer_test.sv =====
`timescale 1ns / 100ps

// Checks operand_list_reducer against a model of the accumulator. Every operand
// transfer is run through that model as it is accepted. Each run total that the
// model (or a row of the directed table) expects waits in a queue until the
// block delivers it on the result channel. Both sides idle at random.
module operand_list_reducer_test;
  import olr_pkg::*;

  localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POS = 32'h7fff_ffff;
  localparam int TOTAL_ITEMS     = 1600;
  localparam int HOLD_OFF_AFTER  = 40;   // totals taken before the long receiver hold-off
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 60;   // leaves room for a trailing divide to finish

  typedef struct packed {
    logic [DATA_W-1:0] operand;
    logic [1:0]        op;
    logic              first;
    logic              last;
  } operand_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] total;
    logic              div_err;
  } run_total_t;

  // One row of the directed table. Where given is set, the expected total is
  // typed into the row; elsewhere the model supplies it.
  typedef struct packed {
    operand_item_t item;
    logic          given;
    run_total_t    want;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_operand = '0;
  logic [1:0]               in_req_type = OP_ADD;
  logic                     in_is_first = 1'b0;
  logic                     in_is_last = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b1;
  logic signed [DATA_W-1:0] out_result;
  logic                     out_div_error;

  // Model state: the accumulator and the sticky division error.
  logic [DATA_W-1:0] model_acc = '0;
  logic              model_err = 1'b0;

  run_total_t pending_totals[$];
  stim_row_t  directed_rows[$];
  int         mismatch_count = 0;
  int         totals_taken = 0;
  int         items_sent = 0;
  bit         sender_calm = 1'b0;
  bit         receiver_calm = 1'b0;

  operand_list_reducer DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operand    (in_operand),
    .in_req_type   (in_req_type),
    .in_is_first   (in_is_first),
    .in_is_last    (in_is_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_result    (out_result),
    .out_div_error (out_div_error)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Advances the model by one accepted transfer. Returns 1 when the transfer
  // closes a run; the run total is then in tot.
  function automatic bit reduce_step(input operand_item_t it, output run_total_t tot);
    logic [DATA_W-1:0] mag_n;
    logic [DATA_W-1:0] mag_d;
    logic [DATA_W-1:0] quo;
    if (it.first) begin
      // A run start loads the accumulator whatever the operation says.
      model_acc = it.operand;
      model_err = 1'b0;
    end else begin
      case (it.op)
        OP_ADD: model_acc = model_acc + it.operand;
        OP_SUB: model_acc = model_acc - it.operand;
        OP_MUL: model_acc = model_acc * it.operand;
        OP_DIV: begin
          if (it.operand == '0) begin
            // Division by zero keeps the accumulator and marks the run.
            model_err = 1'b1;
          end else begin
            // Divide magnitudes, then fix the sign: truncates toward zero, and
            // the most negative value over minus one wraps back onto itself.
            mag_n = model_acc[DATA_W-1] ? -model_acc : model_acc;
            mag_d = it.operand[DATA_W-1] ? -it.operand : it.operand;
            quo = mag_n / mag_d;
            model_acc = (model_acc[DATA_W-1] ^ it.operand[DATA_W-1]) ? -quo : quo;
          end
        end
      endcase
    end
    tot.total = model_acc;
    tot.div_err = model_err;
    return it.last;
  endfunction

  // Idle cycles before the next transfer. Now and then a side switches into a
  // calm stretch in which it does not idle at all.
  function automatic int idle_cycles(inout bit calm);
    if ($urandom_range(0, 29) == 0) begin
      calm = ~calm;
    end
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  // Operands lean toward the values where arithmetic goes wrong: zero, one,
  // minus one, the extremes, and small numbers that keep products in range.
  function automatic logic [DATA_W-1:0] random_operand();
    case ($urandom_range(0, 9)) inside
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return MOST_NEG;
      4: return MOST_POS;
      5, 6: return 32'($urandom_range(0, 200)) - 32'd100;
      7: return 32'($urandom_range(1, 65535));
      default: return $urandom();
    endcase
  endfunction

  function automatic void add_row(input logic [DATA_W-1:0] opnd, input logic [1:0] op,
                                  input logic first, input logic last, input logic given,
                                  input logic [DATA_W-1:0] total, input logic err);
    stim_row_t row;
    row.item.operand = opnd;
    row.item.op = op;
    row.item.first = first;
    row.item.last = last;
    row.given = given;
    row.want.total = total;
    row.want.div_err = err;
    directed_rows.push_back(row);
  endfunction

  // Offers one operand transfer and waits until it is accepted. The valid
  // stays high when the next transfer follows with no gap, so it is never
  // lowered and raised within one time step.
  task automatic offer(input operand_item_t it, input logic given, input run_total_t want);
    int gap;
    run_total_t tot;
    gap = idle_cycles(sender_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operand <= it.operand;
    in_req_type <= it.op;
    in_is_first <= it.first;
    in_is_last <= it.last;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (reduce_step(it, tot)) begin
      pending_totals.push_back(given ? want : tot);
    end
  endtask

  // Stops offering and waits until every expected total has been delivered.
  task automatic wait_for_totals();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_totals.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    operand_item_t it;
    int shape;
    int run_len;
    bit paused;
    paused = 1'b0;

    // Directed part: reset state, wrap-around at the extremes, every
    // operation, division by zero, the sticky flag and the ignored opcode.
    // A later operand right after reset works on the cleared accumulator.
    add_row(32'd5,        OP_ADD, 1'b0, 1'b1, 1'b1, 32'd5,    1'b0);
    add_row(MOST_POS,     OP_ADD, 1'b1, 1'b1, 1'b1, MOST_POS, 1'b0);
    add_row(MOST_NEG,     OP_SUB, 1'b1, 1'b1, 1'b1, MOST_NEG, 1'b0);
    add_row(MOST_POS,     OP_ADD, 1'b1, 1'b0, 1'b0, '0,       1'b0);
    add_row(32'd1,        OP_ADD, 1'b0, 1'b1, 1'b1, MOST_NEG, 1'b0);
    add_row(MOST_NEG,     OP_MUL, 1'b1, 1'b0, 1'b0, '0,       1'b0);
    add_row(32'd1,        OP_SUB, 1'b0, 1'b1, 1'b1, MOST_POS, 1'b0);
    // The most negative value divided by minus one wraps onto itself.
    add_row(MOST_NEG,     OP_DIV, 1'b1, 1'b0, 1'b0, '0,       1'b0);
    add_row('1,           OP_DIV, 1'b0, 1'b1, 1'b1, MOST_NEG, 1'b0);
    // Division by zero keeps the accumulator and sets the flag, which
    // survives into an operand that continues after the run has ended.
    add_row(32'd7,        OP_ADD, 1'b1, 1'b0, 1'b0, '0,       1'b0);
    add_row('0,           OP_DIV, 1'b0, 1'b1, 1'b1, 32'd7,    1'b1);
    add_row(32'd3,        OP_ADD, 1'b0, 1'b1, 1'b1, 32'd10,   1'b1);
    // First and last at once, with a divide opcode that must be ignored.
    add_row(32'd12345,    OP_DIV, 1'b1, 1'b1, 1'b1, 32'd12345, 1'b0);
    add_row(-32'sd7,      OP_ADD, 1'b1, 1'b0, 1'b0, '0,       1'b0);
    add_row(32'd2,        OP_DIV, 1'b0, 1'b1, 1'b1, -32'sd3,  1'b0);
    add_row(32'h1_0000,   OP_MUL, 1'b1, 1'b0, 1'b0, '0,       1'b0);
    add_row(32'h1_0000,   OP_MUL, 1'b0, 1'b1, 1'b1, '0,       1'b0);
    add_row('1,           OP_ADD, 1'b1, 1'b0, 1'b0, '0,       1'b0);
    add_row(MOST_NEG,     OP_MUL, 1'b0, 1'b1, 1'b1, MOST_NEG, 1'b0);
    // A longer mixed run, left to the model.
    add_row(32'd100,      OP_MUL, 1'b1, 1'b0, 1'b0, '0,       1'b0);
    add_row(-32'sd50,     OP_SUB, 1'b0, 1'b0, 1'b0, '0,       1'b0);
    add_row('0,           OP_DIV, 1'b0, 1'b0, 1'b0, '0,       1'b0);
    add_row(32'hdead_beef, OP_MUL, 1'b0, 1'b0, 1'b0, '0,      1'b0);
    add_row(32'd7,        OP_DIV, 1'b0, 1'b0, 1'b0, '0,       1'b0);
    add_row('1,           OP_DIV, 1'b0, 1'b1, 1'b0, '0,       1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].item, directed_rows[i].given, directed_rows[i].want);
    end
    wait_for_totals();

    // Random part: mostly well-formed runs with random content. The rest are
    // loose transfers, runs dropped before their last operand, and runs that
    // continue an old accumulator without a run start.
    while (items_sent < TOTAL_ITEMS) begin
      if (!paused && items_sent >= TOTAL_ITEMS / 2) begin
        paused = 1'b1;
        wait_for_totals();
      end
      shape = $urandom_range(0, 19);
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
      for (int k = 0; k < run_len; k++) begin
        it.operand = random_operand();
        it.op = 2'($urandom_range(0, 3));
        it.first = (k == 0);
        it.last = (k == run_len - 1);
        case (shape)
          0: begin
            it.first = 1'($urandom_range(0, 1));
            it.last = 1'($urandom_range(0, 1));
          end
          1: it.last = 1'b0;
          2: it.first = 1'b0;
          default: ;
        endcase
        offer(it, 1'b0, '0);
      end
    end

    wait_for_totals();
    // A trailing transfer without a last flag may still be in the divider;
    // give it time in case it wrongly produces a result.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_totals.size() == 0) begin
      $display("operand_list_reducer_test passed");
    end else begin
      $display("operand_list_reducer_test failed");
    end
    $finish;
  end

  // Receiver: stalls a random number of cycles before each result transfer.
  // Once, it holds off for a long stretch while the sender keeps offering,
  // so that the output register fills and the block stalls its input.
  initial begin : result_receiver
    int wait_cycles;
    bit held_off;
    held_off = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      wait_cycles = idle_cycles(receiver_calm);
      if (!held_off && totals_taken >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        wait_cycles = HOLD_OFF_CYCLES;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compares each accepted result transfer with the oldest expected total.
  always @(posedge clk) begin : check_totals
    run_total_t want;
    if (rst_n && out_valid && !out_stall) begin
      totals_taken++;
      if (pending_totals.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected: result %h div_error %b",
                 $realtime, out_result, out_div_error);
      end else begin
        want = pending_totals.pop_front();
        if (out_result !== want.total) begin
          mismatch_count++;
          $display("%0t: result mismatch: expected %h, got %h",
                   $realtime, want.total, out_result);
        end
        if (out_div_error !== want.div_err) begin
          mismatch_count++;
          $display("%0t: div_error mismatch: expected %b, got %b",
                   $realtime, want.div_err, out_div_error);
        end
      end
    end
  end

  initial begin : watchdog
    #15_000_000;
    $display("operand_list_reducer_test failed");
    $finish;
  end

endmodule
